// ----- sv/sfcd_pkg.sv -----
// Shared constants and types for the SBUS frame channel decoder.
`default_nettype none
package sfcd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int PAYLOAD_LEN = 11;
    localparam int NUM_CHANS   = 8;
    localparam int CHAN_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int PAYLOAD_W   = PAYLOAD_LEN * BYTE_W;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
    localparam logic [CHAN_W-1:0] CHAN_MASK  = 11'h7FF;
    localparam logic [POS_W-1:0]  POS_IDLE   = '0;
    localparam logic [POS_W-1:0]  POS_FIRST  = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic                 done;
        logic [PAYLOAD_W-1:0] payload;
    } t_cap_out;

    typedef logic [CHAN_W-1:0] t_chan;

endpackage
`default_nettype wire

// ----- sv/sbus_frame_channel_decoder_core.sv -----
// Top level of the SBUS frame channel decoder.
// Takes one serial byte per beat, hunts for the 0x0F start byte, counts a
// 25-byte frame and on its last byte emits channels 1 to 8 as one result beat.
// A byte is registered on entry and handled in the following cycle, and the
// result register is loaded in that same cycle, so a byte may be taken on
// every clock; a frame's result passes through the entry register and then the
// result register. Input stalls only while a result is held by a stalled output.
`default_nettype none
module sbus_frame_channel_decoder_core
    import sfcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BYTE_W-1:0] i_byte_in,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CHAN_W-1:0]      o_chan1,
    output logic [CHAN_W-1:0]      o_chan2,
    output logic [CHAN_W-1:0]      o_chan3,
    output logic [CHAN_W-1:0]      o_chan4,
    output logic [CHAN_W-1:0]      o_chan5,
    output logic [CHAN_W-1:0]      o_chan6,
    output logic [CHAN_W-1:0]      o_chan7,
    output logic [CHAN_W-1:0]      o_chan8
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              busy;
    logic              step;
    logic              in_take;
    t_cap_out          cap;
    t_chan             chans [NUM_CHANS];

    assign step    = r_in_valid && !busy;
    assign o_stall = r_in_valid && busy;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_in;
        end
    end

    sfcd_frame_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_cap   (cap)
    );

    sfcd_chan_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (cap),
        .i_load  (step && cap.done),
        .i_stall (i_stall),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_chans (chans)
    );

    assign o_chan1 = chans[0];
    assign o_chan2 = chans[1];
    assign o_chan3 = chans[2];
    assign o_chan4 = chans[3];
    assign o_chan5 = chans[4];
    assign o_chan6 = chans[5];
    assign o_chan7 = chans[6];
    assign o_chan8 = chans[7];

endmodule
`default_nettype wire

// ----- sv/sfcd_frame_capture.sv -----
// Frame position tracking and payload byte capture.
`default_nettype none
module sfcd_frame_capture
    import sfcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_cap_out               o_cap
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] r_payload [PAYLOAD_LEN];
    logic [BYTE_W-1:0] n_payload [PAYLOAD_LEN];
    logic              n_done;

    always_comb begin
        n_pos  = r_pos;
        n_done = 1'b0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            n_payload[i] = (i_step && r_pos == POS_W'(i + 1)) ? i_byte : r_payload[i];
        end
        if (i_step) begin
            if (r_pos == POS_IDLE) begin
                if (i_byte == START_BYTE) begin
                    n_pos = POS_FIRST;
                end
            end else if (r_pos == POS_LAST) begin
                // last byte of the frame, value ignored
                n_pos  = POS_IDLE;
                n_done = 1'b1;
            end else begin
                n_pos = r_pos + POS_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            r_payload[i] <= n_payload[i];
        end
    end

    // present the next payload and done flag combinationally, not the registered ones
    always_comb begin
        o_cap.done = n_done;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            o_cap.payload[i*BYTE_W +: BYTE_W] = n_payload[i];
        end
    end

endmodule
`default_nettype wire

// ----- sv/sfcd_chan_unpack.sv -----
// Channel unpacking and result register.
`default_nettype none
module sfcd_chan_unpack
    import sfcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cap_out i_cap,
    input  wire logic     i_load,
    input  wire logic     i_stall,
    output logic          o_busy,
    output logic          o_valid,
    output t_chan         o_chans [NUM_CHANS]
);

    logic  r_valid;
    t_chan r_chans [NUM_CHANS];
    t_chan n_chans [NUM_CHANS];

    // channels are packed little-endian, 11 bits each from payload bit 0
    always_comb begin
        for (int k = 0; k < NUM_CHANS; k++) begin
            n_chans[k] = i_cap.payload[k*CHAN_W +: CHAN_W] & CHAN_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_CHANS; k++) begin
                r_chans[k] <= n_chans[k];
            end
        end
    end

    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    always_comb begin
        for (int k = 0; k < NUM_CHANS; k++) begin
            o_chans[k] = r_chans[k];
        end
    end

endmodule
`default_nettype wire

// ----- sv/sfcd_checker.sv -----
// Port-level checks for the SBUS frame channel decoder, with bind.
`default_nettype none
module sfcd_checker
    import sfcd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [CHAN_W-1:0] o_chan1,
    input wire logic [CHAN_W-1:0] o_chan8
);

    // a held result beat stays valid and keeps channels 1 and 8
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_chan1) && $stable(o_chan8))
        else $error("stalled result beat changed");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without blocked output");

    // reset empties both the result and the entry register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("state not cleared by reset");

    // a stall on input lasts only while the output is still blocked
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall not released");

endmodule

bind sbus_frame_channel_decoder_core sfcd_checker u_sfcd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_chan1 (o_chan1),
    .o_chan8 (o_chan8)
);
`default_nettype wire

// ----- test/sfcd_frame_checker.sv -----
// Frame decoder checker: predicts each channel result beat from the byte stream and compares.
`timescale 1ns / 1ps
module sfcd_frame_checker
    import sfcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [BYTE_W-1:0] i_byte_in,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [CHAN_W-1:0] i_chan1,
    input  wire logic [CHAN_W-1:0] i_chan2,
    input  wire logic [CHAN_W-1:0] i_chan3,
    input  wire logic [CHAN_W-1:0] i_chan4,
    input  wire logic [CHAN_W-1:0] i_chan5,
    input  wire logic [CHAN_W-1:0] i_chan6,
    input  wire logic [CHAN_W-1:0] i_chan7,
    input  wire logic [CHAN_W-1:0] i_chan8,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Index 0 holds channel 1.
    typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] t_chan_set;

    logic [POS_W-1:0]  frame_pos = POS_IDLE;
    logic [BYTE_W-1:0] payload_bytes [PAYLOAD_LEN];
    t_chan_set         frames_due [$];
    int                mismatches = 0;

    function automatic t_chan_set unpack_channels();
        logic [PAYLOAD_W-1:0] packed_bits;
        t_chan_set            chans;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            packed_bits[i*BYTE_W +: BYTE_W] = payload_bytes[i];
        end
        for (int k = 0; k < NUM_CHANS; k++) begin
            chans[k] = packed_bits[k*CHAN_W +: CHAN_W];
        end
        return chans;
    endfunction

    task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
        if (frame_pos == POS_IDLE) begin
            // drop everything but the start byte while hunting
            if (b == START_BYTE) begin
                frame_pos = POS_FIRST;
            end
        end else begin
            if (frame_pos <= POS_W'(PAYLOAD_LEN)) begin
                payload_bytes[frame_pos - 1'b1] = b;
            end
            if (frame_pos == POS_LAST) begin
                frames_due.push_back(unpack_channels());
                frame_pos = POS_IDLE;
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_chan_set got;
        t_chan_set want;
        got = {i_chan8, i_chan7, i_chan6, i_chan5, i_chan4, i_chan3, i_chan2, i_chan1};
        if (!i_rst_n) begin
            frame_pos = POS_IDLE;
            frames_due.delete();
        end else begin
            // compare the output beat first: it belongs to an earlier frame
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result beat with nothing expected, chan1 %0d",
                                 $realtime, i_chan1);
                    end
                end else begin
                    want = frames_due.pop_front();
                    for (int k = 0; k < NUM_CHANS; k++) begin
                        if (got[k] !== want[k]) begin
                            mismatches++;
                            if (mismatches <= REPORT_LIMIT) begin
                                $display("%0t: chan%0d mismatch: expected %0d, got %0d",
                                         $realtime, k + 1, want[k], got[k]);
                            end
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                track_frame_byte(i_byte_in);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frames_due.size();
    end

endmodule

// ----- test/tb_sbus_frame_channel_decoder_core.sv -----
// Testbench top for the frame decoder: drives byte and stall stimulus and gives the verdict.
`timescale 1ns / 1ps
module tb_sbus_frame_channel_decoder_core;
    import sfcd_pkg::*;

    localparam int TARGET_BYTES = 950;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        PAT_RANDOM,
        PAT_ZEROS,
        PAT_ONES,
        PAT_STARTS
    } t_pattern;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte;
    logic              out_valid;
    logic              out_stall;
    logic [CHAN_W-1:0] chan1, chan2, chan3, chan4, chan5, chan6, chan7, chan8;
    int                fail_count;
    int                pending;

    int                frame_bytes_sent = 0;
    int                cycle_count = 0;
    logic              steady = 1'b0;

    sbus_frame_channel_decoder_core dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_valid   (in_valid),
        .o_stall   (in_stall),
        .i_byte_in (in_byte),
        .o_valid   (out_valid),
        .i_stall   (out_stall),
        .o_chan1   (chan1),
        .o_chan2   (chan2),
        .o_chan3   (chan3),
        .o_chan4   (chan4),
        .o_chan5   (chan5),
        .o_chan6   (chan6),
        .o_chan7   (chan7),
        .o_chan8   (chan8)
    );

    sfcd_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_byte_in    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_chan1      (chan1),
        .i_chan2      (chan2),
        .i_chan3      (chan3),
        .i_chan4      (chan4),
        .i_chan5      (chan5),
        .i_chan6      (chan6),
        .i_chan7      (chan7),
        .i_chan8      (chan8),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Output back-pressure: mostly free, short stalls, the odd long one.
    initial begin : stall_gen
        int pick;
        out_stall <= 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end else if (pick < 55) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end else if (pick < 93) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Bytes sent while the block hunts for a start; never the start byte itself.
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = any_byte();
        if (b == START_BYTE) begin
            b = ~START_BYTE;
        end
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] payload_byte(input t_pattern pat);
        case (pat)
            PAT_ZEROS: begin
                return '0;
            end
            PAT_ONES: begin
                return '1;
            end
            PAT_STARTS: begin
                return $urandom_range(0, 1) ? START_BYTE : any_byte();
            end
            default: begin
                return any_byte();
            end
        endcase
    endfunction

    // Hold the beat until it is taken; raise valid only after any gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit in_frame);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (in_frame) begin
            frame_bytes_sent++;
        end
    endtask

    task automatic send_frame(input t_pattern pat);
        send_byte(START_BYTE, 1'b1);
        for (int pos = 1; pos < FRAME_BYTES; pos++) begin
            if (pos <= PAYLOAD_LEN) begin
                send_byte(payload_byte(pat), 1'b1);
            end else if (pat == PAT_RANDOM) begin
                send_byte(($urandom_range(0, 7) == 0) ? START_BYTE : any_byte(), 1'b1);
            end else begin
                // start bytes inside the frame are plain data
                send_byte(START_BYTE, 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        int pick;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle bytes either side of the start code, then a full-scale frame
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(START_BYTE - 1'b1, 1'b0);
        send_frame(PAT_ONES);

        while (frame_bytes_sent < TARGET_BYTES) begin
            if ($urandom_range(0, 4) == 0) begin
                steady = ~steady;
            end
            repeat ($urandom_range(0, 2)) send_byte(noise_byte(), 1'b0);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(PAT_RANDOM);
            end else if (pick < 70) begin
                send_frame(PAT_ZEROS);
            end else if (pick < 78) begin
                send_frame(PAT_ONES);
            end else if (pick < 87) begin
                send_frame(PAT_STARTS);
            end else begin
                // cut a frame short; the next bytes complete it out of step
                send_byte(START_BYTE, 1'b1);
                repeat ($urandom_range(1, FRAME_BYTES - 2)) send_byte(any_byte(), 1'b1);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
